/* rtl/sfla_pkg.sv */
`timescale 1ns / 1ps

package sfla_pkg;

  // opcodes of an input transaction
  localparam logic [2:0] OP_TEMP_ALLOC = 3'd0;
  localparam logic [2:0] OP_TEMP_CLEAR = 3'd1;
  localparam logic [2:0] OP_ALLOC      = 3'd2;
  localparam logic [2:0] OP_FREE       = 3'd3;
  localparam logic [2:0] OP_REALLOC    = 3'd4;

  // result error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_MEM     = 2'd1;
  localparam logic [1:0] ERR_CORRUPT = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BASE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_TOP     = 2'd2;

  // fixed field widths
  localparam int unsigned FIELD_ADDR_W = 16;
  localparam int unsigned CFG_DATA_W   = 16;

endpackage

/* rtl/sfla_ram.sv */
`timescale 1ns / 1ps

module sfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/segregated_free_list_string_allocator_top.sv */
`timescale 1ns / 1ps

// String allocator over one byte memory of 2**ADDR_BITS entries: a temporary stack
// growing upward from temp_base and a heap of control-byte-led buffers growing down
// from string_top, with one descending-address free list per size class linked
// through the buffers themselves. Each transaction is handled by a sequencer around
// the single-port memory (one access per cycle, registered read). A list alloc or a
// pop reads the link and then updates the head; a free that is not at the heap
// bottom walks the free list node by node and then writes the links, so the cost of
// free and realloc grows with the length of the free list. One transaction is worked
// on at a time; a finished result waits in an output register while the next
// transaction is accepted. The memory needs no clearing after reset.
module segregated_free_list_string_allocator_top #(
  parameter int unsigned ADDR_BITS    = 16,
  parameter int unsigned SIZE_CLASSES = 16,
  parameter int unsigned BLOCK_BYTES  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sfla_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         opcode_i,
  input  logic [7:0]                         byte_count_i,
  input  logic [3:0]                         block_count_i,
  input  logic [sfla_pkg::FIELD_ADDR_W-1:0]  buffer_addr_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sfla_pkg::FIELD_ADDR_W-1:0]  result_addr_o,
  output logic [1:0]                         error_code_o
);

  import sfla_pkg::*;

  localparam int unsigned AW   = ADDR_BITS;
  localparam int unsigned CW   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int unsigned LB   = (ADDR_BITS + 7) / 8;
  localparam int unsigned LIW  = (LB > 1) ? $clog2(LB) : 1;
  localparam int unsigned XW   = AW + 12;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [XW-1:0] MASK_X = XW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ALLOC, S_FREE, S_FR_CLS, S_WALK, S_WALK_CHK, S_FIX,
    S_AFTER, S_RC_CLS, S_POP, S_LR, S_LA, S_WL, S_FIN
  } state_e;

  typedef enum logic [1:0] {FM_PLAIN, FM_SHRINK, FM_GROW} free_mode_e;

  state_e state_q, lret_q, wret_q;
  free_mode_e fmode_q;

  // configuration and pointers
  logic [AW-1:0] const_limit_q, temp_base_q, string_top_q;
  logic [AW-1:0] heap_bottom_q, temp_top_q;
  logic [AW-1:0] heads_q [SIZE_CLASSES];

  // transaction registers
  logic [2:0]      op_q;
  logic [7:0]      bytes_q;
  logic [3:0]      blocks_q;
  logic [AW-1:0]   addr_q;
  logic [CW-1:0]   cls_q, want_q, pc_q;
  logic [AW-1:0]   res_q;
  logic [1:0]      err_q;
  logic [AW-1:0]   cur_q, prev_q;
  logic [AW-1:0]   lnode_q, wnode_q, wval_q;
  logic [LIW-1:0]  lidx_q, widx_q;
  logic [LB*8-1:0] lacc_q;

  // output register
  logic                    out_valid_q;
  logic [FIELD_ADDR_W-1:0] out_res_q;
  logic [1:0]              out_err_q;
  logic                    fin_fire;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  // derived values
  logic [AW-1:0]   ctrl;
  logic            rd_cls_ok;
  logic [CW-1:0]   rd_cls;
  logic [CW-1:0]   want;
  logic            want_ok;
  logic [XW-1:0]   hb_x, tt_x, need_x, span_rd_x, sum_tmp_x, nb_alloc_x, nb_free_x;
  logic            alloc_fail;
  logic [AW-1:0]   hb_free_new;
  logic [LB*8-1:0] wext;
  logic [7:0]      wbyte;
  logic [AW-1:0]   head_cls, head_want;

  sfla_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // size class wanted by a realloc length
  always_comb begin
    want    = '0;
    want_ok = int'(bytes_q) < SIZE_CLASSES * BLOCK_BYTES;
    for (int k = 1; k < SIZE_CLASSES; k++) begin
      if (int'(bytes_q) >= k * BLOCK_BYTES) begin
        want = CW'(k);
      end
    end
  end

  // pointer arithmetic
  always_comb begin
    ctrl        = addr_q - AW'(1);
    rd_cls_ok   = int'(mem_rdata) < SIZE_CLASSES;
    rd_cls      = mem_rdata[CW-1:0];
    head_cls    = heads_q[cls_q];
    head_want   = heads_q[want_q];
    hb_x        = XW'(heap_bottom_q);
    tt_x        = XW'(temp_top_q);
    need_x      = XW'((int'(cls_q) + 1) * BLOCK_BYTES + 1);
    span_rd_x   = XW'((int'(rd_cls) + 1) * BLOCK_BYTES + 1);
    sum_tmp_x   = tt_x + XW'(bytes_q);
    nb_alloc_x  = hb_x - need_x;
    alloc_fail  = (hb_x < need_x + XW'(1)) || (nb_alloc_x + XW'(1) <= tt_x);
    nb_free_x   = hb_x + span_rd_x;
    hb_free_new = (nb_free_x > MASK_X) ? MASK_X[AW-1:0] : nb_free_x[AW-1:0];
    wext        = (LB*8)'(wval_q);
    wbyte       = wext[8*(int'(LB) - 1 - int'(widx_q)) +: 8];
  end

  // result handed to the output register this cycle
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // memory access per state
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state_q)
      S_DEC:   mem_addr = ctrl;
      S_FREE:  mem_addr = ctrl;
      S_ALLOC: begin
        mem_addr  = nb_alloc_x[AW-1:0];
        mem_wdata = 8'(cls_q);
        mem_we    = (head_cls == '0) && !alloc_fail;
      end
      S_LR:    mem_addr = lnode_q + AW'(lidx_q) + AW'(1);
      S_WL: begin
        mem_we    = 1'b1;
        mem_addr  = wnode_q + AW'(widx_q) + AW'(1);
        mem_wdata = wbyte;
      end
      default: mem_addr = '0;
    endcase
  end

  // sequencer, pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lret_q        <= S_IDLE;
      wret_q        <= S_IDLE;
      fmode_q       <= FM_PLAIN;
      const_limit_q <= AW'(16384);
      temp_base_q   <= AW'(32768);
      string_top_q  <= AW'(65535);
      heap_bottom_q <= AW'(65535);
      temp_top_q    <= AW'(32768);
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        heads_q[i] <= '0;
      end
      lidx_q        <= '0;
      widx_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CONSTANT_LIMIT: const_limit_q <= AW'(cfg_data_i);
          CFG_TEMP_BASE:      temp_base_q   <= AW'(cfg_data_i);
          CFG_STRING_TOP:     string_top_q  <= AW'(cfg_data_i);
          default:            ;
        endcase
      end

      // output valid flag
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= opcode_i;
            bytes_q  <= byte_count_i;
            blocks_q <= block_count_i;
            addr_q   <= AW'(buffer_addr_i);
            state_q  <= S_DEC;
          end
        end

        S_DEC: begin
          fmode_q <= FM_PLAIN;
          want_q  <= want;
          case (op_q)
            OP_TEMP_ALLOC: begin
              state_q <= S_FIN;
              if (sum_tmp_x >= hb_x) begin
                temp_top_q <= temp_base_q;
                res_q      <= '0;
                err_q      <= ERR_MEM;
              end else begin
                res_q      <= temp_top_q;
                err_q      <= ERR_OK;
                temp_top_q <= sum_tmp_x[AW-1:0];
              end
            end
            OP_TEMP_CLEAR: begin
              temp_top_q <= temp_base_q;
              res_q      <= '0;
              err_q      <= ERR_OK;
              state_q    <= S_FIN;
            end
            OP_ALLOC: begin
              res_q <= '0;
              if (int'(blocks_q) >= SIZE_CLASSES) begin
                err_q   <= ERR_MEM;
                state_q <= S_FIN;
              end else begin
                err_q   <= ERR_OK;
                cls_q   <= blocks_q[CW-1:0];
                state_q <= S_ALLOC;
              end
            end
            OP_FREE: begin
              res_q   <= '0;
              err_q   <= ERR_OK;
              state_q <= S_FREE;
            end
            OP_REALLOC: begin
              res_q <= '0;
              if (bytes_q == '0) begin
                err_q   <= ERR_OK;
                state_q <= S_FREE;
              end else if (!want_ok) begin
                err_q   <= ERR_MEM;
                state_q <= S_FIN;
              end else if (addr_q == '0 || addr_q < const_limit_q) begin
                err_q   <= ERR_OK;
                cls_q   <= want;
                state_q <= S_ALLOC;
              end else begin
                err_q   <= ERR_OK;
                state_q <= S_RC_CLS;
              end
            end
            default: begin
              res_q   <= '0;
              err_q   <= ERR_OK;
              state_q <= S_FIN;
            end
          endcase
        end

        // take a list head or carve a new buffer off the heap bottom
        S_ALLOC: begin
          if (head_cls != '0) begin
            res_q   <= head_cls + AW'(1);
            pc_q    <= cls_q;
            lnode_q <= head_cls;
            lidx_q  <= '0;
            lacc_q  <= '0;
            lret_q  <= S_POP;
            state_q <= S_LR;
          end else if (alloc_fail) begin
            res_q   <= '0;
            err_q   <= ERR_MEM;
            state_q <= S_FIN;
          end else begin
            heap_bottom_q <= nb_alloc_x[AW-1:0];
            res_q         <= nb_alloc_x[AW-1:0] + AW'(1);
            state_q       <= S_FIN;
          end
        end

        S_POP: begin
          heads_q[pc_q] <= lacc_q[AW-1:0];
          state_q       <= S_FIN;
        end

        // range check then read the control byte
        S_FREE: begin
          if (addr_q == '0 || ctrl < heap_bottom_q || ctrl >= string_top_q) begin
            state_q <= S_AFTER;
          end else begin
            state_q <= S_FR_CLS;
          end
        end

        S_FR_CLS: begin
          if (!rd_cls_ok) begin
            res_q   <= '0;
            err_q   <= ERR_CORRUPT;
            state_q <= S_FIN;
          end else if (ctrl == heap_bottom_q) begin
            heap_bottom_q <= hb_free_new;
            state_q       <= S_AFTER;
          end else begin
            cls_q   <= rd_cls;
            cur_q   <= heads_q[rd_cls];
            prev_q  <= '0;
            state_q <= S_WALK;
          end
        end

        // walk the descending list to the insertion point
        S_WALK: begin
          if (cur_q > ctrl) begin
            lnode_q <= cur_q;
            lidx_q  <= '0;
            lacc_q  <= '0;
            lret_q  <= S_WALK_CHK;
            state_q <= S_LR;
          end else begin
            wnode_q <= ctrl;
            wval_q  <= cur_q;
            widx_q  <= '0;
            wret_q  <= S_FIX;
            state_q <= S_WL;
          end
        end

        S_WALK_CHK: begin
          if (lacc_q[AW-1:0] >= cur_q) begin
            res_q   <= '0;
            err_q   <= ERR_CORRUPT;
            state_q <= S_FIN;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= lacc_q[AW-1:0];
            state_q <= S_WALK;
          end
        end

        // link the predecessor or the head to the freed buffer
        S_FIX: begin
          if (prev_q != '0) begin
            wnode_q <= prev_q;
            wval_q  <= ctrl;
            widx_q  <= '0;
            wret_q  <= S_AFTER;
            state_q <= S_WL;
          end else begin
            heads_q[cls_q] <= ctrl;
            state_q        <= S_AFTER;
          end
        end

        // continue after a successful free
        S_AFTER: begin
          case (fmode_q)
            FM_SHRINK: begin
              res_q <= head_want + AW'(1);
              if (head_want != '0) begin
                pc_q    <= want_q;
                lnode_q <= head_want;
                lidx_q  <= '0;
                lacc_q  <= '0;
                lret_q  <= S_POP;
                state_q <= S_LR;
              end else begin
                state_q <= S_FIN;
              end
            end
            FM_GROW: begin
              cls_q   <= want_q;
              state_q <= S_ALLOC;
            end
            default: begin
              res_q   <= '0;
              state_q <= S_FIN;
            end
          endcase
        end

        // realloc: class of the existing buffer decides the path
        S_RC_CLS: begin
          if (!rd_cls_ok) begin
            err_q   <= ERR_CORRUPT;
            state_q <= S_FIN;
          end else if (int'(want_q) <= int'(mem_rdata)) begin
            if (head_want > addr_q) begin
              fmode_q <= FM_SHRINK;
              state_q <= S_FREE;
            end else begin
              res_q   <= addr_q;
              state_q <= S_FIN;
            end
          end else begin
            fmode_q <= FM_GROW;
            state_q <= S_FREE;
          end
        end

        // link read, big-endian, one byte per S_LR/S_LA pair
        S_LR: state_q <= S_LA;

        S_LA: begin
          lacc_q <= (lacc_q << 8) | (LB*8)'(mem_rdata);
          if (lidx_q == LIW'(LB - 1)) begin
            state_q <= lret_q;
          end else begin
            lidx_q  <= lidx_q + LIW'(1);
            state_q <= S_LR;
          end
        end

        // link write, one byte per cycle
        S_WL: begin
          if (widx_q == LIW'(LB - 1)) begin
            state_q <= wret_q;
          end else begin
            widx_q <= widx_q + LIW'(1);
          end
        end

        // hand the result to the output register
        S_FIN: begin
          if (fin_fire) begin
            out_res_q   <= FIELD_ADDR_W'(res_q);
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_res_q;
  assign error_code_o  = out_err_q;

  // list walk moves strictly downward
  a_walk_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && $past(state_q) == S_WALK_CHK) |-> (cur_q < $past(cur_q)))
    else $error("free-list walk did not descend");

  // link byte counters stay within the link
  a_link_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(lidx_q) < LB) && (int'(widx_q) < LB))
    else $error("link byte index out of range");

  // heap bottom moves only on alloc or bottom free
  a_hb_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heap_bottom_q) |-> ($past(state_q) == S_ALLOC || $past(state_q) == S_FR_CLS))
    else $error("heap bottom changed outside alloc or free");

  // a delivered result never carries an unknown error code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o == ERR_OK || error_code_o == ERR_MEM ||
                     error_code_o == ERR_CORRUPT))
    else $error("bad error code");

endmodule
